>>> design/mvaw_pkg.sv
// ---------------------------------------------------------------------------
// mvaw_pkg
// Shared widths, defaults and controller/datapath interface types for the
// moving average with warm-up.
// ---------------------------------------------------------------------------
package mvaw_pkg;

    localparam int SAMPLE_W          = 24;
    localparam int USED_W            = 4;
    localparam int WINDOW_LENGTH_DEF = 8;

    // commands from controller to datapath
    typedef struct packed {
        logic load;      // take a sample into the window
        logic sum_upd;   // fold the pending difference into the sum
        logic div_init;  // take magnitude, clear remainder and step count
        logic div_step;  // one restoring divide step
        logic out_load;  // capture the signed quotient into the output word
    } mvaw_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic div_last;  // current divide step is the final one
    } mvaw_sts_t;

endpackage

>>> design/mvaw_datapath.sv
// ---------------------------------------------------------------------------
// mvaw_datapath
// Delay line, running sum, fill counter, bit-serial restoring divider and
// output word register.
// ---------------------------------------------------------------------------
module mvaw_datapath #(
    parameter int WINDOW_LENGTH = mvaw_pkg::WINDOW_LENGTH_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  mvaw_pkg::mvaw_cmd_t                   cmd,
    output mvaw_pkg::mvaw_sts_t                   sts,
    input  logic signed [mvaw_pkg::SAMPLE_W-1:0]  sample,
    output logic signed [mvaw_pkg::SAMPLE_W-1:0]  average,
    output logic        [mvaw_pkg::USED_W-1:0]    samples_used
);

    localparam int SW     = mvaw_pkg::SAMPLE_W;
    localparam int UW     = mvaw_pkg::USED_W;
    localparam int SUM_W  = SW + $clog2(WINDOW_LENGTH);
    localparam int CNT_W  = $clog2(WINDOW_LENGTH + 1);
    localparam int ITER_W = $clog2(SUM_W);

    logic signed [SW-1:0]    dline_reg [WINDOW_LENGTH];
    logic signed [SW:0]      diff_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic                    neg_reg;
    logic [SUM_W-1:0]        quo_reg;
    logic [CNT_W-1:0]        rem_reg;
    logic [ITER_W-1:0]       iter_reg;
    logic signed [SW-1:0]    avg_reg;
    logic [UW-1:0]           used_reg;

    logic [SUM_W-1:0]        sum_u;
    logic [CNT_W:0]          rem_shift;
    logic [CNT_W:0]          trial;
    logic [SW-1:0]           quo_low;
    logic [SW-1:0]           avg_next;
    logic [CNT_W+UW-1:0]     cnt_ext;

    assign sum_u     = sum_reg;
    assign rem_shift = {rem_reg, quo_reg[SUM_W-1]};
    assign trial     = rem_shift - {1'b0, cnt_reg};
    assign quo_low   = quo_reg[SW-1:0];
    assign avg_next  = neg_reg ? -quo_low : quo_low;
    assign cnt_ext   = {{UW{1'b0}}, cnt_reg};

    assign sts.div_last = (iter_reg == ITER_W'(SUM_W - 1));

    // window, sum and counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < WINDOW_LENGTH; i++) begin
                dline_reg[i] <= '0;
            end
            sum_reg <= '0;
            cnt_reg <= '0;
        end else begin
            if (cmd.load) begin
                dline_reg[0] <= sample;
                for (int i = 1; i < WINDOW_LENGTH; i++) begin
                    dline_reg[i] <= dline_reg[i-1];
                end
                if (cnt_reg != CNT_W'(WINDOW_LENGTH)) begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
            if (cmd.sum_upd) begin
                sum_reg <= sum_reg + SUM_W'(diff_reg);
            end
        end
    end

    // difference of new and dropped sample, then divider
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            diff_reg <= (SW+1)'(sample) - (SW+1)'(dline_reg[WINDOW_LENGTH-1]);
        end
        if (cmd.div_init) begin
            neg_reg  <= sum_reg[SUM_W-1];
            quo_reg  <= sum_reg[SUM_W-1] ? -sum_u : sum_u;
            rem_reg  <= '0;
            iter_reg <= '0;
        end else if (cmd.div_step) begin
            iter_reg <= iter_reg + 1'b1;
            if (!trial[CNT_W]) begin
                rem_reg <= trial[CNT_W-1:0];
                quo_reg <= {quo_reg[SUM_W-2:0], 1'b1};
            end else begin
                rem_reg <= rem_shift[CNT_W-1:0];
                quo_reg <= {quo_reg[SUM_W-2:0], 1'b0};
            end
        end
        if (cmd.out_load) begin
            avg_reg  <= avg_next;
            used_reg <= cnt_ext[UW-1:0];
        end
    end

    assign average      = avg_reg;
    assign samples_used = used_reg;

endmodule

>>> design/mvaw_ctrl.sv
// ---------------------------------------------------------------------------
// mvaw_ctrl
// Sequencer for one sample at a time: window update, sum update, divide,
// then hand-off into the output word register.
// ---------------------------------------------------------------------------
module mvaw_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    output mvaw_pkg::mvaw_cmd_t  cmd,
    input  mvaw_pkg::mvaw_sts_t  sts
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SUM  = 3'd1;
    localparam logic [2:0] ST_ABS  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;
    logic       out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        s_ready      = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
                if (s_valid) begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM: begin
                cmd.sum_upd = 1'b1;
                state_next  = ST_ABS;
            end
            ST_ABS: begin
                cmd.div_init = 1'b1;
                state_next   = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (sts.div_last) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                // wait for the output word to drain
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

>>> design/moving_average_warmup_core.sv
// ---------------------------------------------------------------------------
// moving_average_warmup_core
// Boxcar moving average with warm-up divisor.
// ---------------------------------------------------------------------------
// Input channel s_valid/s_ready/s_sample: one signed 24-bit sample (8
// fractional bits) per word. Output channel m_valid/m_ready carries
// m_average (same format, truncated toward zero) and m_samples_used, the
// number of samples averaged (low 4 bits of the count).
// Every accepted sample gives exactly one output word. Each sample passes
// through the window, sum and sign steps, then the bit-serial restoring
// divider, one quotient bit per cycle over SUM_W = 24 + clog2(WINDOW_LENGTH)
// bits (27 at the default window of 8), then the hand-off into the output
// word register. One sample is in work at a time, so the next sample is
// taken only after the previous one has been handed off.
// The output word sits in its own register: the next sample is accepted
// while a finished word waits; if the receiver still stalls when the next
// quotient is ready, the sequencer holds until the register frees up.
// Synchronous reset clears the delay line, running sum and fill count;
// the next sample then averages over itself alone.
// ---------------------------------------------------------------------------
module moving_average_warmup_core #(
    parameter int WINDOW_LENGTH = mvaw_pkg::WINDOW_LENGTH_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [mvaw_pkg::SAMPLE_W-1:0]  s_sample,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [mvaw_pkg::SAMPLE_W-1:0]  m_average,
    output logic        [mvaw_pkg::USED_W-1:0]    m_samples_used
);

    mvaw_pkg::mvaw_cmd_t cmd;
    mvaw_pkg::mvaw_sts_t sts;

    mvaw_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    mvaw_datapath #(
        .WINDOW_LENGTH (WINDOW_LENGTH)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .sts          (sts),
        .sample       (s_sample),
        .average      (m_average),
        .samples_used (m_samples_used)
    );

endmodule

>>> design/mvaw_checker.sv
// ---------------------------------------------------------------------------
// mvaw_checker
// Port-level checks for the moving average core, bound to the top level.
// ---------------------------------------------------------------------------
module mvaw_checker (
    input logic                                  aclk,
    input logic                                  aresetn,
    input logic                                  s_valid,
    input logic                                  s_ready,
    input logic signed [mvaw_pkg::SAMPLE_W-1:0]  s_sample,
    input logic                                  m_valid,
    input logic                                  m_ready,
    input logic signed [mvaw_pkg::SAMPLE_W-1:0]  m_average,
    input logic        [mvaw_pkg::USED_W-1:0]    m_samples_used
);

    // stalled word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_average)
                                && $stable(m_samples_used))
        else $error("output word changed while stalled");

    // no word appears from nothing right after reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("core not idle after reset");

    // one sample in work: busy during the sum and sign steps that follow
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready ##1 !s_ready)
        else $error("sample taken while previous one in work");

    // a word cannot complete during the sum and sign steps of a take while drained
    a_no_early: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !m_valid |=> !m_valid ##1 !m_valid)
        else $error("output word appeared too early");

    // waiting input word keeps valid and sample until taken
    a_sample_known: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_sample))
        else $error("input word changed before accept");

endmodule

bind moving_average_warmup_core mvaw_checker u_mvaw_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .s_sample       (s_sample),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_average      (m_average),
    .m_samples_used (m_samples_used)
);
